FILE: design/gmi_pkg.sv
// Shared constants, codes and types for the Gram matrix block.
// Depends on nothing; every other file of the block uses it by scoped names.
`timescale 1ns / 1ps

package gmi_pkg;

   // Store geometry
   localparam int STORE_DEPTH = 4096;
   localparam int ADDR_W      = $clog2(STORE_DEPTH);
   localparam int CNT_W       = $clog2(STORE_DEPTH + 2);

   // Field widths
   localparam int DATA_W   = 64;
   localparam int HALF_W   = 32;
   localparam int DIM_W    = 13;
   localparam int IDX_W    = 12;
   localparam int NEED_W   = 2 * DIM_W;
   localparam int STATUS_W = 2;

   // Register port
   localparam int PADDR_W = 3;
   localparam int PDATA_W = 32;

   typedef enum logic {
      OP_LOAD = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK       = 2'd0,
      ST_SIZE_ERR = 2'd1,
      ST_NONE     = 2'd2
   } status_type;

   typedef enum logic {
      REG_ROW_COUNT = 1'b0,
      REG_COL_COUNT = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      S_IDLE  = 2'd0,
      S_ISSUE = 2'd1,
      S_WAIT  = 2'd2
   } seq_state_type;

   // Register values and the write strobe, from the register port to control
   typedef struct packed {
      logic             wr;
      logic [DIM_W-1:0] row_count;
      logic [DIM_W-1:0] col_count;
   } cfg_type;

   // Control that travels with each pair of store reads through the MAC
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } mac_ctl_type;

endpackage

FILE: design/gmi_req_if.sv
// Request channel of the Gram matrix block: valid/ready with one item.
// Depends on gmi_pkg for field widths.
`timescale 1ns / 1ps

interface gmi_req_if;
   logic                              valid;
   logic                              ready;
   logic                              opcode;
   logic signed [gmi_pkg::DATA_W-1:0] element;
   logic                              load_last;

   modport source (output valid, output opcode, output element, output load_last,
                   input ready);
   modport sink   (input valid, input opcode, input element, input load_last,
                   output ready);
endinterface

FILE: design/gmi_rsp_if.sv
// Response channel of the Gram matrix block: valid/ready with one result item.
// Depends on gmi_pkg for field widths.
`timescale 1ns / 1ps

interface gmi_rsp_if;
   logic                                valid;
   logic                                ready;
   logic signed [gmi_pkg::DATA_W-1:0]   value;
   logic        [gmi_pkg::IDX_W-1:0]    out_row;
   logic        [gmi_pkg::IDX_W-1:0]    out_col;
   logic        [gmi_pkg::STATUS_W-1:0] status;
   logic                                result_last;

   modport source (output valid, output value, output out_row, output out_col,
                   output status, output result_last, input ready);
   modport sink   (input valid, input value, input out_row, input out_col,
                   input status, input result_last, output ready);
endinterface

FILE: design/gmi_store.sv
// Matrix store: one write port and two read ports, read data registered.
// Depends on gmi_pkg for depth and widths.
`timescale 1ns / 1ps

module gmi_store (
   input  logic                        clock,
   input  logic                        we,
   input  logic [gmi_pkg::ADDR_W-1:0]  waddr,
   input  logic [gmi_pkg::DATA_W-1:0]  wdata,
   input  logic                        re,
   input  logic [gmi_pkg::ADDR_W-1:0]  raddr_a,
   input  logic [gmi_pkg::ADDR_W-1:0]  raddr_b,
   output logic [gmi_pkg::DATA_W-1:0]  rdata_a,
   output logic [gmi_pkg::DATA_W-1:0]  rdata_b
);

   logic [gmi_pkg::DATA_W-1:0] mem [gmi_pkg::STORE_DEPTH];
   logic [gmi_pkg::DATA_W-1:0] rd_a_ff;
   logic [gmi_pkg::DATA_W-1:0] rd_b_ff;

   // Write one element
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
   end

   // Read two elements
   always_ff @(posedge clock) begin
      if (re) begin
         rd_a_ff <= mem[raddr_a];
         rd_b_ff <= mem[raddr_b];
      end
   end

   assign rdata_a = rd_a_ff;
   assign rdata_b = rd_b_ff;

endmodule

FILE: design/gmi_mac.sv
// Pipelined 64-bit multiply-accumulate, product split into 32-bit partial products.
// Depends on gmi_pkg; fed by the read ports of gmi_store.
`timescale 1ns / 1ps

module gmi_mac (
   input  logic                        clock,
   input  logic                        reset,
   input  gmi_pkg::mac_ctl_type        issue,
   input  logic [gmi_pkg::DATA_W-1:0]  x,
   input  logic [gmi_pkg::DATA_W-1:0]  y,
   output logic [gmi_pkg::DATA_W-1:0]  acc,
   output logic                        done
);

   localparam int HW = gmi_pkg::HALF_W;

   gmi_pkg::mac_ctl_type       ctl1_ff;
   gmi_pkg::mac_ctl_type       ctl2_ff;
   gmi_pkg::mac_ctl_type       ctl3_ff;
   logic [gmi_pkg::DATA_W-1:0] pp_ll_ff;
   logic [HW-1:0]              pp_lh_ff;
   logic [HW-1:0]              pp_hl_ff;
   logic [gmi_pkg::DATA_W-1:0] prod_ff;
   logic [gmi_pkg::DATA_W-1:0] acc_ff;
   logic                       done_ff;

   logic [gmi_pkg::DATA_W-1:0] pp_ll_in;
   logic [HW-1:0]              pp_lh_in;
   logic [HW-1:0]              pp_hl_in;
   logic [HW-1:0]              cross_sum;
   logic [gmi_pkg::DATA_W-1:0] prod_in;
   logic [gmi_pkg::DATA_W-1:0] acc_in;

   // Low 64 bits of the product: low*low plus the two cross terms shifted up
   always_comb begin
      pp_ll_in  = gmi_pkg::DATA_W'(x[HW-1:0]) * gmi_pkg::DATA_W'(y[HW-1:0]);
      pp_lh_in  = x[HW-1:0] * y[gmi_pkg::DATA_W-1:HW];
      pp_hl_in  = x[gmi_pkg::DATA_W-1:HW] * y[HW-1:0];
      cross_sum = pp_lh_ff + pp_hl_ff;
      prod_in   = pp_ll_ff + {cross_sum, {HW{1'b0}}};
      acc_in    = ctl3_ff.first ? prod_ff : acc_ff + prod_ff;
   end

   // Advance the control flags alongside the data
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl1_ff <= '0;
         ctl2_ff <= '0;
         ctl3_ff <= '0;
         done_ff <= 1'b0;
      end else begin
         ctl1_ff <= issue;
         ctl2_ff <= ctl1_ff;
         ctl3_ff <= ctl2_ff;
         done_ff <= ctl3_ff.valid && ctl3_ff.last;
      end
   end

   // Partial products, product, accumulator
   always_ff @(posedge clock) begin
      if (ctl1_ff.valid) begin
         pp_ll_ff <= pp_ll_in;
         pp_lh_ff <= pp_lh_in;
         pp_hl_ff <= pp_hl_in;
      end
      if (ctl2_ff.valid) begin
         prod_ff <= prod_in;
      end
      if (ctl3_ff.valid) begin
         acc_ff <= acc_in;
      end
   end

   assign acc  = acc_ff;
   assign done = done_ff;

endmodule

FILE: design/gmi_csr.sv
// Register port: row and column counts behind an APB-style write/read port.
// Depends on gmi_pkg for the register layout and the cfg_type struct.
`timescale 1ns / 1ps

module gmi_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gmi_pkg::PADDR_W-1:0] paddr,
   input  logic [gmi_pkg::PDATA_W-1:0] pwdata,
   output logic [gmi_pkg::PDATA_W-1:0] prdata,
   output logic                        pready,
   output gmi_pkg::cfg_type            cfg
);

   localparam int DW = gmi_pkg::DIM_W;

   logic [DW-1:0]          row_count_ff;
   logic [DW-1:0]          row_count_in;
   logic [DW-1:0]          col_count_ff;
   logic [DW-1:0]          col_count_in;
   logic                   wr;
   gmi_pkg::reg_index_type index;

   assign index = gmi_pkg::reg_index_type'(paddr[2]);
   assign wr    = psel && penable && pwrite;

   // Decode the write
   always_comb begin
      row_count_in = row_count_ff;
      col_count_in = col_count_ff;
      if (wr) begin
         case (index)
            gmi_pkg::REG_ROW_COUNT: row_count_in = pwdata[DW-1:0];
            gmi_pkg::REG_COL_COUNT: col_count_in = pwdata[DW-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_count_ff <= DW'(1);
         col_count_ff <= DW'(1);
      end else begin
         row_count_ff <= row_count_in;
         col_count_ff <= col_count_in;
      end
   end

   // Read back
   always_comb begin
      case (index)
         gmi_pkg::REG_ROW_COUNT: prdata = gmi_pkg::PDATA_W'(row_count_ff);
         gmi_pkg::REG_COL_COUNT: prdata = gmi_pkg::PDATA_W'(col_count_ff);
         default:                prdata = '0;
      endcase
   end

   assign pready        = 1'b1;
   assign cfg.wr        = wr;
   assign cfg.row_count = row_count_ff;
   assign cfg.col_count = col_count_ff;

endmodule

FILE: design/gram_matrix_int64_core.sv
// Top level of the Gram matrix block: load sequencing, read walk and result register.
// Depends on gmi_pkg, gmi_req_if, gmi_rsp_if, gmi_store, gmi_mac and gmi_csr.
`timescale 1ns / 1ps

// Loads a matrix of signed 64-bit elements one per load item into a 4096-entry
// store, answers the last load item with a status (ok or size error), then
// returns G = A * A^T one entry per read item, row by row, each entry a wrapping
// 64-bit dot product of two rows, or a status of none if no read-out is pending
// or a count is zero. A read item streams one element of each of the two rows
// per cycle from the store into a single multiply-accumulate unit; the data then
// passes the store read register, three MAC pipeline stages (partial products,
// product, accumulator) with the completion flag raised beside the accumulator,
// and the result register. One item is worked on at a time; a finished result
// waits in the output register, and the next item is taken no earlier than the
// cycle in which that result leaves. Writing either count register ends any
// pending read-out. The store needs no clearing after reset.

module gram_matrix_int64_core (
   input  logic                        clock,
   input  logic                        reset,
   gmi_req_if.sink                     req_if,
   gmi_rsp_if.source                   rsp_if,
   input  logic                        psel,
   input  logic                        penable,
   input  logic                        pwrite,
   input  logic [gmi_pkg::PADDR_W-1:0] paddr,
   input  logic [gmi_pkg::PDATA_W-1:0] pwdata,
   output logic [gmi_pkg::PDATA_W-1:0] prdata,
   output logic                        pready
);

   localparam int CW = gmi_pkg::CNT_W;
   localparam int DW = gmi_pkg::DIM_W;
   localparam int AW = gmi_pkg::ADDR_W;

   gmi_pkg::cfg_type       cfg;
   gmi_pkg::seq_state_type state_ff;
   gmi_pkg::seq_state_type state_in;
   gmi_pkg::mac_ctl_type   issue;

   logic [CW-1:0] load_count_ff, load_count_in, count_bump;
   logic          ready_ff, ready_in;
   logic [DW-1:0] i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [CW-1:0] base_i_ff, base_i_in, base_j_ff, base_j_in;
   logic [CW-1:0] addr_a_ff, addr_a_in, addr_b_ff, addr_b_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [gmi_pkg::DATA_W-1:0]    rsp_value_ff, rsp_value_in;
   logic [gmi_pkg::IDX_W-1:0]     rsp_row_ff, rsp_row_in, rsp_col_ff, rsp_col_in;
   gmi_pkg::status_type           rsp_status_ff, rsp_status_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          accept, take, req_ready;
   logic                          is_load;
   logic [gmi_pkg::NEED_W-1:0]    need;
   logic                          size_ok;
   logic [DW-1:0]                 rows_m1, cols_m1;
   logic                          k_last, row_done, fin, dims_zero;
   logic [CW-1:0]                 cols_ext;
   logic                          st_we;
   logic [gmi_pkg::DATA_W-1:0]    rd_a, rd_b;
   logic [gmi_pkg::DATA_W-1:0]    mac_acc;
   logic                          mac_done;

   gmi_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   gmi_store u_store (
      .clock   (clock),
      .we      (st_we),
      .waddr   (load_count_ff[AW-1:0]),
      .wdata   (req_if.element),
      .re      (issue.valid),
      .raddr_a (addr_a_ff[AW-1:0]),
      .raddr_b (addr_b_ff[AW-1:0]),
      .rdata_a (rd_a),
      .rdata_b (rd_b)
   );

   gmi_mac u_mac (
      .clock (clock),
      .reset (reset),
      .issue (issue),
      .x     (rd_a),
      .y     (rd_b),
      .acc   (mac_acc),
      .done  (mac_done)
   );

   // Handshake: take an item when idle and the result slot is free or draining
   assign req_ready    = (state_ff == gmi_pkg::S_IDLE) && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready = req_ready;
   assign accept       = req_if.valid && req_ready;
   assign take         = rsp_valid_ff && rsp_if.ready;
   assign is_load      = gmi_pkg::opcode_type'(req_if.opcode) == gmi_pkg::OP_LOAD;

   // Size check and walk bounds
   always_comb begin
      count_bump = (load_count_ff <= CW'(gmi_pkg::STORE_DEPTH)) ?
                   load_count_ff + 1'b1 : load_count_ff;
      need       = gmi_pkg::NEED_W'(cfg.row_count) * gmi_pkg::NEED_W'(cfg.col_count);
      size_ok    = (gmi_pkg::NEED_W'(count_bump) == need) &&
                   (count_bump <= CW'(gmi_pkg::STORE_DEPTH));
      rows_m1    = cfg.row_count - 1'b1;
      cols_m1    = cfg.col_count - 1'b1;
      cols_ext   = CW'(cfg.col_count);
      k_last     = (k_ff == cols_m1);
      row_done   = (j_ff == rows_m1);
      fin        = row_done && (i_ff == rows_m1);
      dims_zero  = (cfg.row_count == '0) || (cfg.col_count == '0);
      st_we      = accept && is_load && (load_count_ff < CW'(gmi_pkg::STORE_DEPTH));
      issue.valid = (state_ff == gmi_pkg::S_ISSUE);
      issue.first = (k_ff == '0);
      issue.last  = k_last;
   end

   // Next state and datapath control
   always_comb begin
      state_in      = state_ff;
      load_count_in = load_count_ff;
      ready_in      = ready_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      k_in          = k_ff;
      base_i_in     = base_i_ff;
      base_j_in     = base_j_ff;
      addr_a_in     = addr_a_ff;
      addr_b_in     = addr_b_ff;
      rsp_valid_in  = rsp_valid_ff && !take;
      rsp_value_in  = rsp_value_ff;
      rsp_row_in    = rsp_row_ff;
      rsp_col_in    = rsp_col_ff;
      rsp_status_in = rsp_status_ff;
      rsp_last_in   = rsp_last_ff;

      case (state_ff)
         gmi_pkg::S_IDLE: begin
            if (accept && is_load) begin
               ready_in      = 1'b0;
               load_count_in = count_bump;
               if (req_if.load_last) begin
                  load_count_in = '0;
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_row_in    = '0;
                  rsp_col_in    = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = size_ok ? gmi_pkg::ST_OK : gmi_pkg::ST_SIZE_ERR;
                  if (size_ok) begin
                     ready_in  = 1'b1;
                     i_in      = '0;
                     j_in      = '0;
                     base_i_in = '0;
                     base_j_in = '0;
                  end
               end
            end else if (accept) begin
               if (!ready_ff || dims_zero) begin
                  rsp_valid_in  = 1'b1;
                  rsp_value_in  = '0;
                  rsp_row_in    = '0;
                  rsp_col_in    = '0;
                  rsp_last_in   = 1'b0;
                  rsp_status_in = gmi_pkg::ST_NONE;
               end else begin
                  state_in  = gmi_pkg::S_ISSUE;
                  k_in      = '0;
                  addr_a_in = base_i_ff;
                  addr_b_in = base_j_ff;
               end
            end
         end
         gmi_pkg::S_ISSUE: begin
            // Stream one element pair per cycle into the MAC
            k_in      = k_ff + 1'b1;
            addr_a_in = addr_a_ff + 1'b1;
            addr_b_in = addr_b_ff + 1'b1;
            if (k_last) begin
               state_in = gmi_pkg::S_WAIT;
            end
         end
         gmi_pkg::S_WAIT: begin
            if (mac_done) begin
               state_in      = gmi_pkg::S_IDLE;
               rsp_valid_in  = 1'b1;
               rsp_value_in  = mac_acc;
               rsp_row_in    = i_ff[gmi_pkg::IDX_W-1:0];
               rsp_col_in    = j_ff[gmi_pkg::IDX_W-1:0];
               rsp_status_in = gmi_pkg::ST_OK;
               rsp_last_in   = fin;
               // Step to the next entry of G
               if (fin) begin
                  ready_in  = 1'b0;
                  i_in      = '0;
                  j_in      = '0;
                  base_i_in = '0;
                  base_j_in = '0;
               end else if (row_done) begin
                  i_in      = i_ff + 1'b1;
                  j_in      = '0;
                  base_i_in = base_i_ff + cols_ext;
                  base_j_in = '0;
               end else begin
                  j_in      = j_ff + 1'b1;
                  base_j_in = base_j_ff + cols_ext;
               end
            end
         end
         default: begin
            state_in = gmi_pkg::S_IDLE;
         end
      endcase

      // A count register write ends any pending read-out
      if (cfg.wr) begin
         ready_in = 1'b0;
      end
   end

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= gmi_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         load_count_ff <= '0;
         ready_ff      <= 1'b0;
         i_ff          <= '0;
         j_ff          <= '0;
         k_ff          <= '0;
         base_i_ff     <= '0;
         base_j_ff     <= '0;
         addr_a_ff     <= '0;
         addr_b_ff     <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         load_count_ff <= load_count_in;
         ready_ff      <= ready_in;
         i_ff          <= i_in;
         j_ff          <= j_in;
         k_ff          <= k_in;
         base_i_ff     <= base_i_in;
         base_j_ff     <= base_j_in;
         addr_a_ff     <= addr_a_in;
         addr_b_ff     <= addr_b_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      rsp_value_ff  <= rsp_value_in;
      rsp_row_ff    <= rsp_row_in;
      rsp_col_ff    <= rsp_col_in;
      rsp_status_ff <= rsp_status_in;
      rsp_last_ff   <= rsp_last_in;
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.value       = rsp_value_ff;
   assign rsp_if.out_row     = rsp_row_ff;
   assign rsp_if.out_col     = rsp_col_ff;
   assign rsp_if.status      = rsp_status_ff;
   assign rsp_if.result_last = rsp_last_ff;

`ifndef SYNTHESIS
   a_done_in_wait: assert property (@(posedge clock) disable iff (reset)
      mac_done |-> state_ff == gmi_pkg::S_WAIT)
      else $error("MAC finished outside the wait state");

   a_slot_free_in_issue: assert property (@(posedge clock) disable iff (reset)
      state_ff == gmi_pkg::S_ISSUE |-> !rsp_valid_ff)
      else $error("result register busy while a read is in progress");

   a_ready_dims: assert property (@(posedge clock) disable iff (reset)
      ready_ff |-> (cfg.row_count != '0) && (cfg.col_count != '0))
      else $error("read-out pending with a zero dimension");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      load_count_ff <= CW'(gmi_pkg::STORE_DEPTH + 1))
      else $error("load counter beyond its saturation value");
`endif

endmodule
